### hw/rtl/dbct_pkg.sv
// Shared types and constants of the decaying bucket count table.
// Holds field widths, action codes, the register map and the
// controller-to-datapath command and status structs. No dependencies.
package dbct_pkg;

	// Bucket count used unless the top level is given another
	localparam int N_BUCKETS_DEF = 1024;

	// Field widths
	localparam int VALUE_W  = 21;	// feature value, signed Q4.16
	localparam int WEIGHT_W = 16;	// insert weight, Q8.8
	localparam int COUNT_W  = 32;	// bucket count, Q16.16
	localparam int FACTOR_W = 17;	// decay factor, Q1.16
	localparam int BIDX_W   = 10;	// reported bucket index
	localparam int FRAC_W   = 16;	// fraction bits of value, count and factor
	localparam int WSHIFT   = 8;	// Q8.8 weight to Q16.16 count

	// Decay factor reset value and unity
	localparam logic [FACTOR_W-1:0] DECAY_RESET = FACTOR_W'(52429);
	localparam logic [FACTOR_W-1:0] DECAY_ONE   = FACTOR_W'(65536);

	// Register port
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic REG_DECAY_FACTOR = 1'b0;	// register index, paddr[2]

	// Operation codes
	typedef enum logic [1:0] {
		ACT_INSERT = 2'd0,
		ACT_QUERY  = 2'd1,
		ACT_DECAY  = 2'd2,
		ACT_CLEAR  = 2'd3
	} action_t;

	// Controller commands to the datapath
	typedef struct packed {
		logic load_item;	// capture an accepted beat
		logic map;		// value times N-1
		logic wrap;		// fold into range, issue counter read
		logic update;		// read-modify-write of the counter
		logic sweep_dec;	// decay sweep: issue read of the current entry
		logic sweep_clr;	// clear sweep: write zero to the current entry
		logic out_load;		// move the result into the output register
	} dbct_cmd_t;

	// Datapath status to the controller
	typedef struct packed {
		action_t act;		// action of the item in flight
		logic sweep_last;	// sweep counter at the last entry
		logic pipe_empty;	// no decay write pending
		logic out_free;		// output register can take a result
	} dbct_sts_t;

endpackage

### hw/rtl/decaying_bucket_count_table.sv
// Decaying bucket count table: a memory of N_BUCKETS Q16.16 counters
// addressed by a signed Q4.16 feature value mapped to floor(value*(N-1)),
// negative buckets wrapped modulo N, large ones clamped to N-1. Insert
// adds a Q8.8 weight with saturation, query reads a counter, decay scales
// every counter by the decay_factor register (capped at one), clear
// zeroes the table. Each accepted beat gives one result beat. An insert
// or query goes from acceptance to the result through the mapping
// multiply, the wrap step and the read-modify-write through the
// single counter memory. Decay and clear sweep the table one memory
// entry per cycle. After reset a clearing pass over every entry
// runs before the first item is accepted; register writes are taken
// during it. The output register lets the next item be accepted while
// a result waits.
// Depends on dbct_pkg, dbct_ctrl, dbct_dp and dbct_ram.
module decaying_bucket_count_table
	import dbct_pkg::*;
#(
	parameter int N_BUCKETS = N_BUCKETS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// Item channel
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [1:0]                action,
	input  logic signed [VALUE_W-1:0] feature_value,
	input  logic [WEIGHT_W-1:0]       add_weight,
	// Result channel
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [COUNT_W-1:0]        bucket_count,
	output logic [BIDX_W-1:0]         bucket_index,
	output logic                      saturated,
	// Register port
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [PADDR_W-1:0]        paddr,
	input  logic [PDATA_W-1:0]        pwdata,
	output logic [PDATA_W-1:0]        prdata,
	output logic                      pready
);

	logic [FACTOR_W-1:0] decay_factor_q;
	dbct_cmd_t           cmd;
	dbct_sts_t           sts;

	// Register port: always ready, one register
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_DECAY_FACTOR) ? PDATA_W'(decay_factor_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decay_factor_q <= DECAY_RESET;
		end else if (psel && penable && pwrite && pready
			&& paddr[2] == REG_DECAY_FACTOR) begin
			decay_factor_q <= pwdata[FACTOR_W-1:0];
		end
	end

	dbct_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.action   (action),
		.in_stall (in_stall),
		.cmd      (cmd),
		.sts      (sts)
	);

	dbct_dp #(
		.N_BUCKETS (N_BUCKETS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.action        (action),
		.feature_value (feature_value),
		.add_weight    (add_weight),
		.decay_factor  (decay_factor_q),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.bucket_count  (bucket_count),
		.bucket_index  (bucket_index),
		.saturated     (saturated)
	);

endmodule

### hw/rtl/dbct_ram.sv
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module dbct_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### hw/rtl/dbct_ctrl.sv
// Controller of the decaying bucket count table: one-hot state machine
// that sequences the reset clearing pass, item lookup and table sweeps.
// Depends on dbct_pkg.
module dbct_ctrl
	import dbct_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic [1:0] action,
	output logic      in_stall,
	output dbct_cmd_t cmd,
	input  dbct_sts_t sts
);

	typedef enum logic [7:0] {
		S_INIT   = 8'b0000_0001,
		S_IDLE   = 8'b0000_0010,
		S_MAP    = 8'b0000_0100,
		S_WRAP   = 8'b0000_1000,
		S_UPDATE = 8'b0001_0000,
		S_SWEEP  = 8'b0010_0000,
		S_DRAIN  = 8'b0100_0000,
		S_REPLY  = 8'b1000_0000
	} state_t;

	state_t state_q;
	state_t state_d;

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		in_stall = 1'b1;
		unique case (state_q)
			S_INIT: begin
				cmd.sweep_clr = 1'b1;
				if (sts.sweep_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load_item = 1'b1;
					if (action == ACT_INSERT || action == ACT_QUERY) begin
						state_d = S_MAP;
					end else begin
						state_d = S_SWEEP;
					end
				end
			end
			S_MAP: begin
				cmd.map = 1'b1;
				state_d = S_WRAP;
			end
			S_WRAP: begin
				cmd.wrap = 1'b1;
				state_d = S_UPDATE;
			end
			S_UPDATE: begin
				cmd.update = 1'b1;
				state_d = S_REPLY;
			end
			S_SWEEP: begin
				if (sts.act == ACT_DECAY) begin
					cmd.sweep_dec = 1'b1;
				end else begin
					cmd.sweep_clr = 1'b1;
				end
				if (sts.sweep_last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				if (sts.pipe_empty) begin
					state_d = S_REPLY;
				end
			end
			S_REPLY: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_INIT;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### hw/rtl/dbct_dp.sv
// Datapath of the decaying bucket count table: bucket mapping, counter
// memory, insert adder, decay multiplier pipeline and output register.
// Depends on dbct_pkg and dbct_ram.
module dbct_dp
	import dbct_pkg::*;
#(
	parameter int N_BUCKETS = N_BUCKETS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  dbct_cmd_t                  cmd,
	output dbct_sts_t                  sts,
	input  logic [1:0]                 action,
	input  logic signed [VALUE_W-1:0]  feature_value,
	input  logic [WEIGHT_W-1:0]        add_weight,
	input  logic [FACTOR_W-1:0]        decay_factor,
	input  logic                       out_stall,
	output logic                       out_valid,
	output logic [COUNT_W-1:0]         bucket_count,
	output logic [BIDX_W-1:0]          bucket_index,
	output logic                       saturated
);

	localparam int IDX_W = $clog2(N_BUCKETS);
	localparam int MUL_W = VALUE_W + IDX_W + 1;	// signed value times N-1
	localparam int Q_W   = MUL_W - FRAC_W;		// floor of the product
	localparam int RW    = IDX_W + 5;		// wrap remainder, holds 16*N
	localparam logic [IDX_W-1:0] NM1 = IDX_W'(N_BUCKETS - 1);

	// Item registers
	action_t                    act_q;
	logic signed [VALUE_W-1:0]  value_q;
	logic [WEIGHT_W-1:0]        weight_q;
	logic [FACTOR_W-1:0]        fact_q;
	logic signed [Q_W-1:0]      q_q;
	logic [IDX_W-1:0]           idx_q;
	logic [COUNT_W-1:0]         res_count_q;
	logic                       res_sat_q;

	// Sweep counter and decay pipeline
	logic [IDX_W-1:0]           sweep_q;
	logic                       v_s1;
	logic [IDX_W-1:0]           a_s1;
	logic                       v_s2;
	logic [IDX_W-1:0]           a_s2;
	logic [COUNT_W-1:0]         dec_s2;

	// Output register
	logic                       out_valid_q;
	logic [COUNT_W-1:0]         out_count_q;
	logic [BIDX_W-1:0]          out_index_q;
	logic                       out_sat_q;

	// Combinational
	logic signed [MUL_W-1:0]    prod;
	logic signed [Q_W:0]        q_wide;
	logic [RW-1:0]              rem;
	logic [IDX_W-1:0]           map_idx;
	logic [COUNT_W:0]           sum;
	logic                       sum_sat;
	logic [COUNT_W-1:0]         new_count;
	logic [COUNT_W+FACTOR_W-1:0] dprod;
	logic [FACTOR_W-1:0]        fact_clamp;
	logic                       ram_we;
	logic [IDX_W-1:0]           ram_waddr;
	logic [COUNT_W-1:0]         ram_wdata;
	logic                       ram_re;
	logic [IDX_W-1:0]           ram_raddr;
	logic [COUNT_W-1:0]         rd_data;
	logic                       sweep_adv;

	// Limit the factor to one so decay never grows a count
	assign fact_clamp = (decay_factor > DECAY_ONE) ? DECAY_ONE : decay_factor;

	// Bucket product, floor by taking the upper bits
	assign prod = value_q * $signed({1'b0, NM1});

	// Fold negative buckets into range, clamp large ones
	always_comb begin
		q_wide = {q_q[Q_W-1], q_q} + $signed((Q_W+1)'(N_BUCKETS * 16));
		rem    = RW'(q_wide);
		for (int k = 3; k >= 0; k--) begin
			if (rem >= (RW'(N_BUCKETS) << k)) begin
				rem = rem - (RW'(N_BUCKETS) << k);
			end
		end
		priority if (q_q < 0) begin
			map_idx = IDX_W'(rem);
		end else if (q_q > $signed(Q_W'(N_BUCKETS - 1))) begin
			map_idx = NM1;
		end else begin
			map_idx = IDX_W'(q_q);
		end
	end

	// Insert adder with saturation
	assign sum       = {1'b0, rd_data} + ((COUNT_W+1)'(weight_q) << WSHIFT);
	assign sum_sat   = sum[COUNT_W];
	assign new_count = sum_sat ? '1 : sum[COUNT_W-1:0];

	// Decay multiplier, truncated back to Q16.16
	assign dprod = rd_data * fact_q;

	// Memory port selection
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = new_count;
		priority if (cmd.sweep_clr) begin
			ram_we    = 1'b1;
			ram_waddr = sweep_q;
			ram_wdata = '0;
		end else if (v_s2) begin
			ram_we    = 1'b1;
			ram_waddr = a_s2;
			ram_wdata = dec_s2;
		end else if (cmd.update && act_q == ACT_INSERT) begin
			ram_we    = 1'b1;
		end else begin
			ram_we    = 1'b0;
		end
	end

	assign ram_re    = cmd.wrap | cmd.sweep_dec;
	assign ram_raddr = cmd.wrap ? map_idx : sweep_q;
	assign sweep_adv = cmd.sweep_dec | cmd.sweep_clr;

	dbct_ram #(
		.WIDTH (COUNT_W),
		.DEPTH (N_BUCKETS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (rd_data)
	);

	// Capture the item, map, wrap and update; decay pipeline data and output register
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			value_q     <= feature_value;
			weight_q    <= add_weight;
			fact_q      <= fact_clamp;
			res_count_q <= '0;
			res_sat_q   <= 1'b0;
			idx_q       <= '0;
		end
		if (cmd.map) begin
			q_q <= $signed(prod[MUL_W-1:FRAC_W]);
		end
		if (cmd.wrap) begin
			idx_q <= map_idx;
		end
		if (cmd.update) begin
			res_count_q <= (act_q == ACT_INSERT) ? new_count : rd_data;
			res_sat_q   <= (act_q == ACT_INSERT) & sum_sat;
		end
		a_s1   <= sweep_q;
		a_s2   <= a_s1;
		dec_s2 <= dprod[COUNT_W+FRAC_W-1:FRAC_W];
		if (cmd.out_load) begin
			out_count_q <= res_count_q;
			out_index_q <= BIDX_W'(idx_q);
			out_sat_q   <= res_sat_q;
		end
	end

	// Control registers: action, sweep counter, pipe valids, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q       <= ACT_INSERT;
			sweep_q     <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_item) begin
				act_q <= action_t'(action);
			end
			if (sweep_adv) begin
				sweep_q <= (sweep_q == NM1) ? '0 : sweep_q + 1'b1;
			end
			v_s1 <= cmd.sweep_dec;
			v_s2 <= v_s1;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Status to the controller
	assign sts.act        = act_q;
	assign sts.sweep_last = (sweep_q == NM1);
	assign sts.pipe_empty = ~v_s1 & ~v_s2;
	assign sts.out_free   = ~out_valid_q | ~out_stall;

	assign out_valid    = out_valid_q;
	assign bucket_count = out_count_q;
	assign bucket_index = out_index_q;
	assign saturated    = out_sat_q;

`ifndef SYNTHESIS
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		$past(cmd.wrap) |-> idx_q <= NM1)
		else $error("mapped bucket out of range");

	a_sat_max: assert property (@(posedge clk) disable iff (!arst_n)
		res_sat_q |-> res_count_q == '1)
		else $error("saturated result without full count");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !(out_valid_q && out_stall))
		else $error("result loaded over a waiting beat");

	a_decay_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> dec_s2 <= $past(rd_data))
		else $error("decay grew a count");
`endif

endmodule
